FILE: rtl/sc2a_pkg.sv
// Shared types, scancode constants and key tables for the scancode-to-ASCII block.
// No dependencies; imported by every module of the block.
package sc2a_pkg;

  localparam int SC2A_BUFFER_DEPTH = 128;

  // Item kinds on the input channel (carried in tuser)
  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_READ = 1'b1
  } sc2a_kind_t;

  // Set-1 shift make/break codes
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

  // Character push request from the decoder to the FIFO
  typedef struct packed {
    logic       valid;
    logic [6:0] ch;
  } sc2a_push_t;

  // Key tables, indexed by make code 0x00..0x3F; entries past 0x39 map to nothing.
  localparam logic [6:0] PLAIN_MAP [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFTED_MAP [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
    7'h2F, 7'h28, 7'h29, 7'h3D, 7'h3F, 7'h5E, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h2B,
    7'h2A, 7'h7E, 7'h00, 7'h3E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3B, 7'h3A, 7'h5F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

FILE: rtl/sc2a_decoder.sv
// Scancode decoder: shift tracking, key-down map and table lookup.
// Depends on sc2a_pkg; drives a push request into sc2a_fifo.
module sc2a_decoder
  import sc2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       scan_en,
  input  logic [7:0] scancode,
  output sc2a_push_t push
);

  logic         shift_r;
  logic         shift_nxt;
  logic [127:0] down_r;
  logic         is_shift_make;
  logic         is_shift_break;
  logic         is_break;
  logic         is_new_make;
  logic [6:0]   key;
  logic [6:0]   ch;

  assign key            = scancode[6:0];
  assign is_shift_make  = (scancode == SC_LSHIFT_MAKE) || (scancode == SC_RSHIFT_MAKE);
  assign is_shift_break = (scancode == SC_LSHIFT_BREAK) || (scancode == SC_RSHIFT_BREAK);
  assign is_break       = scancode[7] && !is_shift_break;
  // make of a key not already held; a held key's repeats are ignored
  assign is_new_make    = !scancode[7] && !is_shift_make && !down_r[key];

  always_comb begin
    shift_nxt = shift_r;
    if (scan_en && is_shift_make) begin
      shift_nxt = 1'b1;
    end else if (scan_en && is_shift_break) begin
      shift_nxt = 1'b0;
    end
  end

  // codes 0x40..0x7F are off the table
  always_comb begin
    if (key[6]) begin
      ch = 7'h00;
    end else if (shift_r) begin
      ch = SHIFTED_MAP[key[5:0]];
    end else begin
      ch = PLAIN_MAP[key[5:0]];
    end
  end

  assign push.valid = scan_en && is_new_make && (ch != 7'h00);
  assign push.ch    = ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      down_r  <= '0;
    end else begin
      shift_r <= shift_nxt;
      if (scan_en && is_break) begin
        down_r[key] <= 1'b0;
      end else if (scan_en && is_new_make) begin
        down_r[key] <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/sc2a_fifo.sv
// Character FIFO: circular buffer memory with read/write pointers and fill count.
// Depends on sc2a_pkg; fed by sc2a_decoder, popped by the top level.
module sc2a_fifo
  import sc2a_pkg::*;
#(
  parameter int BUFFER_DEPTH = SC2A_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sc2a_push_t push,
  input  logic       pop_req,
  output logic       pop_ok,
  output logic [6:0] rd_data_r
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  logic [6:0]       mem [BUFFER_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_ok;

  // full buffer drops the character
  assign push_ok = push.valid && (cnt_r != CNT_FULL);
  assign pop_ok  = pop_req && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= push.ch;
    end
    if (pop_ok) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

FILE: rtl/scancode_to_ascii_fifo.sv
// Top level of the PS/2 set-1 scancode to ASCII decoder with character FIFO.
// Depends on sc2a_pkg, sc2a_decoder and sc2a_fifo.
//
//  channel  | direction | tdata                 | tuser
//  ---------+-----------+-----------------------+--------------------------
//  in_*     | slave     | [7:0] scancode        | [0] kind (0 scan, 1 read)
//  out_*    | master    | [6:0] ascii_char, [7]0| [0] char_valid
//
// One transaction per cycle in steady state, unless a read is held back by a
// stalled output. An accepted transaction is held in the input register;
// decode, table lookup and the FIFO update happen as it leaves. A read's result
// is registered in the output register as the read leaves, so out_tvalid rises
// only once the read has passed through the input and output registers.
// Scancode transactions return nothing and keep flowing while a result is
// stalled; a read waits in the input register only while out_tvalid is held.
// Reset clears shift state, the key-down map, FIFO pointers and both valids;
// the FIFO memory itself is not cleared.
module scancode_to_ascii_fifo
  import sc2a_pkg::*;
#(
  parameter int BUFFER_DEPTH = SC2A_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] scancode
  input  logic [0:0] in_tuser,   // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] ascii_char, [7] zero
  output logic [0:0] out_tuser   // [0] char_valid
);

  // input register
  logic       in_valid_r;
  sc2a_kind_t in_kind_r;
  logic [7:0] in_code_r;

  // output register
  logic       out_valid_r;
  logic       char_valid_r;

  logic       advance;
  logic       scan_en;
  logic       pop_req;
  logic       pop_ok;
  logic [6:0] rd_data;
  sc2a_push_t push;

  // a read may leave only when the output slot is free or freeing now
  assign advance   = in_valid_r &&
                     ((in_kind_r == KIND_SCAN) || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign scan_en   = advance && (in_kind_r == KIND_SCAN);
  assign pop_req   = advance && (in_kind_r == KIND_READ);

  sc2a_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .scan_en  (scan_en),
    .scancode (in_code_r),
    .push     (push)
  );

  sc2a_fifo #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_req   (pop_req),
    .pop_ok    (pop_ok),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (pop_req) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= sc2a_kind_t'(in_tuser[0]);
      in_code_r <= in_tdata;
    end
    if (pop_req) begin
      char_valid_r <= pop_ok;
    end
  end

  // read data register holds across stalls; empty reads show zero
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, (char_valid_r ? rd_data : 7'h00)};
  assign out_tuser  = char_valid_r;

endmodule
